FILE: rtl/core/dcm_pkg.sv
// ----------------------------------------------------------------------------
// dcm_pkg: shared types and constants of the motor position controller.
// Command codes, homing phases, config register indices and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package dcm_pkg;

  localparam int SPEED_WINDOW_MS = 50;
  localparam int MIN_REF_SPEED   = 10;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_MOVE  = 3'd1;
  localparam logic [2:0] CMD_MOVBY = 3'd2;
  localparam logic [2:0] CMD_HOME  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;
  localparam logic [2:0] CMD_ZERO  = 3'd5;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_RELEASE  = 2'd1;
  localparam logic [1:0] PH_APPROACH = 2'd2;

  localparam logic [1:0] REG_TOL  = 2'd0;
  localparam logic [1:0] REG_RAMP = 2'd1;
  localparam logic [1:0] REG_MAXS = 2'd2;
  localparam logic [1:0] REG_ZOFS = 2'd3;

  // Datapath work steps from the controller, at most one per cycle; it waits on the divider and output.
  typedef struct packed {
    logic load;     // latch input, run command or tick step 1
    logic spd_go;   // start speed division
    logic spd_done; // write back speed result
    logic home;     // homing and direction
    logic ref_go;   // start reference division
    logic duty;     // final duty step
    logic emit;     // load output register
  } dcm_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic win;      // speed window elapsed
    logic far;      // dist above tolerance
    logic ramp;     // dist below ramp length, division needed
    logic div_busy;
  } dcm_stat_t;

endpackage

FILE: rtl/core/dcm_if.sv
// ----------------------------------------------------------------------------
// dcm_in_if / dcm_out_if / dcm_cfg_if: valid-ready channels.
// ----------------------------------------------------------------------------
interface dcm_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  cmd;
  logic signed [31:0] value;
  logic signed [15:0] encoder_delta;
  logic        [31:0] now_ms;
  logic               home_switch;
  modport source (output valid, cmd, value, encoder_delta, now_ms, home_switch,
                  input ready);
  modport sink   (input valid, cmd, value, encoder_delta, now_ms, home_switch,
                  output ready);
endinterface

interface dcm_out_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  pwm_duty;
  logic               drive_a;
  logic               drive_b;
  logic               busy_res;
  logic signed [31:0] position_now;
  logic        [23:0] speed_now;
  modport source (output valid, pwm_duty, drive_a, drive_b, busy_res, position_now,
                  speed_now, input ready);
  modport sink   (input valid, pwm_duty, drive_a, drive_b, busy_res, position_now,
                  speed_now, output ready);
endinterface

interface dcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dcm_div.sv
// ----------------------------------------------------------------------------
// dcm_div: shared restoring divider, one quotient bit per cycle.
// 48-bit dividend by 32-bit divisor, quotient saturated to 24 bits.
// ----------------------------------------------------------------------------
module dcm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [23:0] quotient
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r[31:0], q_r[47]} - {1'b0, dvs_r};
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd48;
    end else if (cnt_r != 6'd0) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[47]};
        q_nxt   = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign busy     = (cnt_r != 6'd0);
  assign quotient = (q_r[47:24] != 24'd0) ? 24'hFFFFFF : q_r[23:0];
endmodule

FILE: rtl/core/dcm_ctrl.sv
// ----------------------------------------------------------------------------
// dcm_ctrl: sequencer that steps the datapath through one item.
// ----------------------------------------------------------------------------
module dcm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_free,
  input  dcm_pkg::dcm_stat_t stat,
  output dcm_pkg::dcm_cmd_t  cmd,
  output logic             idle
);
  import dcm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_SPD = 3'd1, S_SPW = 3'd2, S_HOME = 3'd3,
                         S_REF = 3'd4, S_REFW = 3'd5, S_DUTY = 3'd6, S_EMIT = 3'd7;
  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_nxt = S_SPD;
      end
      S_SPD: begin
        if (!stat.is_tick) state_nxt = S_EMIT;
        else if (stat.win) begin
          cmd.spd_go = 1'b1;
          state_nxt = S_SPW;
        end else state_nxt = S_HOME;
      end
      S_SPW: if (!stat.div_busy) begin
        cmd.spd_done = 1'b1;
        state_nxt = S_HOME;
      end
      S_HOME: begin
        cmd.home = 1'b1;
        state_nxt = S_REF;
      end
      S_REF: begin
        if (stat.far && stat.ramp) begin
          cmd.ref_go = 1'b1;
          state_nxt = S_REFW;
        end else state_nxt = S_DUTY;
      end
      S_REFW: if (!stat.div_busy) state_nxt = S_DUTY;
      S_DUTY: begin
        cmd.duty = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: if (out_free) begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign idle = (state_r == S_IDLE);
endmodule

FILE: rtl/core/dcm_dp.sv
// ----------------------------------------------------------------------------
// dcm_dp: motor state, configuration registers and step arithmetic.
// ----------------------------------------------------------------------------
module dcm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  dcm_pkg::dcm_cmd_t   cmd,
  output dcm_pkg::dcm_stat_t  stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata,
  input  logic [2:0]        i_cmd,
  input  logic [31:0]       i_value,
  input  logic [15:0]       i_delta,
  input  logic [31:0]       i_now,
  input  logic              i_sw,
  output logic [7:0]        o_duty,
  output logic              o_a,
  output logic              o_b,
  output logic              o_busy,
  output logic [31:0]       o_pos,
  output logic [23:0]       o_speed
);
  import dcm_pkg::*;

  logic [15:0] tol_r;
  logic [23:0] ramp_r;
  logic [15:0] maxs_r;
  logic [31:0] zofs_r;
  logic [31:0] pos_r, tgt_r, lpos_r, ltime_r;
  logic [23:0] spd_r;
  logic [7:0]  lvl_r, duty_r;
  logic        ea_r, eb_r;
  logic [1:0]  ph_r;
  logic [2:0]  c_r;
  logic [31:0] now_r;
  logic        sw_r;
  logic [32:0] dist_r;

  logic [32:0] dist_c, dpos;
  logic [31:0] dt;
  logic        arr_c;
  logic        div_start, div_busy;
  logic [47:0] div_a;
  logic [31:0] div_b;
  logic [23:0] div_q;
  logic [15:0] refs;
  logic signed [25:0] dsp;
  logic signed [33:0] dsc;
  logic [8:0]  lvl_t;

  function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? -d : d;
  endfunction

  assign dist_c = absd(tgt_r, pos_r);
  assign dpos   = absd(pos_r, lpos_r);
  assign arr_c  = dist_c <= {17'd0, tol_r};
  assign dt     = now_r - ltime_r;

  assign div_start = cmd.spd_go | cmd.ref_go;
  // Speed: |dp|*1000 (43 bits) / dt. Reference: max_speed*dist (49 bits worst
  // case only if dist >= ramp, which is excluded, so < 40 bits) / ramp_length.
  assign div_a = cmd.spd_go ? ({15'd0, dpos} * 48'd1000)
                            : ({15'd0, dist_r} * {32'd0, maxs_r});
  assign div_b = cmd.spd_go ? dt : {8'd0, ramp_r};

  dcm_div u_div (.clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
                 .busy(div_busy), .quotient(div_q));

  assign stat.is_tick  = (c_r == CMD_TICK);
  assign stat.win      = dt > 32'(SPEED_WINDOW_MS);
  assign stat.far      = dist_r > {17'd0, tol_r};
  assign stat.ramp     = dist_r < {9'd0, ramp_r};
  assign stat.div_busy = div_busy;

  always_comb begin
    if (!stat.ramp) refs = maxs_r;
    else if (div_q < 24'(MIN_REF_SPEED)) refs = 16'(MIN_REF_SPEED);
    else refs = div_q[15:0];
    dsp = $signed({2'b0, spd_r}) - $signed({10'b0, refs});
    dsc = 34'(dsp) * 34'sd100;
    if (dsc > $signed({1'b0, dist_r}))       lvl_t = {1'b0, lvl_r} - 9'd2;
    else if (dsc < -$signed({1'b0, dist_r})) lvl_t = {1'b0, lvl_r} + 9'd2;
    else                                     lvl_t = {1'b0, lvl_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd2; ramp_r <= 24'd1000; maxs_r <= 16'd1000; zofs_r <= '0;
      pos_r <= '0; tgt_r <= '0; lpos_r <= '0; ltime_r <= '0; spd_r <= '0;
      lvl_r <= '0; duty_r <= '0; ea_r <= 1'b0; eb_r <= 1'b0; ph_r <= PH_IDLE;
      c_r <= CMD_TICK;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TOL:  tol_r  <= cfg_wdata[15:0];
          REG_RAMP: ramp_r <= cfg_wdata[23:0];
          REG_MAXS: maxs_r <= cfg_wdata[15:0];
          REG_ZOFS: zofs_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        c_r <= i_cmd;
        now_r <= i_now;
        sw_r <= i_sw;
        case (i_cmd)
          CMD_TICK:  pos_r <= pos_r + {{16{i_delta[15]}}, i_delta};
          CMD_MOVE:  tgt_r <= i_value;
          CMD_MOVBY: tgt_r <= pos_r + i_value;
          CMD_HOME:  ph_r <= PH_RELEASE;
          CMD_STOP: begin
            ph_r <= PH_IDLE; tgt_r <= pos_r; duty_r <= '0; ea_r <= 1'b0; eb_r <= 1'b0;
          end
          CMD_ZERO: begin
            pos_r <= '0; tgt_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.spd_go) begin
        ltime_r <= now_r;
        lpos_r  <= pos_r;
      end
      if (cmd.spd_done) spd_r <= div_q;
      if (cmd.home) begin
        // Homing and direction use the position after homing, so resolve here.
        logic [31:0] np, nt;
        np = pos_r; nt = tgt_r;
        if (ph_r == PH_RELEASE) begin
          if (sw_r) begin
            if (arr_c) nt = pos_r + {15'd0, tol_r, 1'b0};
          end else ph_r <= PH_APPROACH;
        end else if (ph_r == PH_APPROACH) begin
          if (!sw_r) begin
            if (arr_c) nt = pos_r - {15'd0, tol_r, 1'b0};
          end else begin
            ph_r <= PH_IDLE; np = zofs_r; nt = zofs_r;
          end
        end
        pos_r <= np; tgt_r <= nt;
        if ($signed(nt) < $signed(np)) begin
          ea_r <= 1'b0; eb_r <= 1'b1;
        end else if ($signed(nt) > $signed(np)) begin
          ea_r <= 1'b1; eb_r <= 1'b0;
        end
        dist_r <= absd(nt, np);
      end
      if (cmd.duty) begin
        if (stat.far) begin
          if (lvl_t[8]) begin
            lvl_r <= (lvl_r < 8'd2) ? 8'd0 : 8'd255;
            duty_r <= (lvl_r < 8'd2) ? 8'd0 : 8'd255;
          end else begin
            lvl_r <= lvl_t[7:0]; duty_r <= lvl_t[7:0];
          end
        end else duty_r <= '0;
      end
    end
  end

  assign o_duty  = duty_r;
  assign o_a     = ea_r;
  assign o_b     = eb_r;
  assign o_busy  = (ph_r == PH_RELEASE) || (ph_r == PH_APPROACH) || !arr_c;
  assign o_pos   = pos_r;
  assign o_speed = spd_r;
endmodule

FILE: rtl/core/dc_motor_position_ramp_control.sv
// ----------------------------------------------------------------------------
// dc_motor_position_ramp_control: ramped DC motor position controller.
// Commands and ticks in, one status/drive result per item out.
// ----------------------------------------------------------------------------
// One item at a time. A command goes from load straight to the result; a tick
// also passes the speed, homing, reference and duty steps, with a division on
// the shared divider for the speed update when the window has elapsed
// and for the reference speed inside the ramp. The result sits in an output
// register; the next item is taken once that register is loaded.
module dc_motor_position_ramp_control (
  input logic clk,
  input logic rst_n,
  dcm_in_if.sink    in_ch,
  dcm_out_if.source out_ch,
  dcm_cfg_if.sink   cfg_ch
);
  import dcm_pkg::*;

  dcm_cmd_t  cmd;
  dcm_stat_t stat;
  logic idle, in_fire, out_free, ov_r;
  logic [7:0] duty; logic a, b, busy; logic [31:0] pos; logic [23:0] spd;

  assign in_ch.ready  = idle;
  assign in_fire      = in_ch.valid & idle;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !ov_r || out_ch.ready;

  dcm_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_free, .stat, .cmd, .idle);

  dcm_dp u_dp (.clk, .rst_n, .cmd, .stat,
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_wdata(cfg_ch.data),
    .i_cmd(in_ch.cmd), .i_value(in_ch.value), .i_delta(in_ch.encoder_delta),
    .i_now(in_ch.now_ms), .i_sw(in_ch.home_switch),
    .o_duty(duty), .o_a(a), .o_b(b), .o_busy(busy), .o_pos(pos), .o_speed(spd));

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
    if (cmd.emit) begin
      out_ch.pwm_duty <= duty; out_ch.drive_a <= a; out_ch.drive_b <= b;
      out_ch.busy_res <= busy; out_ch.position_now <= pos; out_ch.speed_now <= spd;
    end
  end
  assign out_ch.valid = ov_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!ov_r || out_ch.ready)) else $error("result overwritten");
  a_idle_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> idle) else $error("not idle after result");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> idle) else $error("load while busy");
endmodule
